>>> rtl/core/tmvm_pkg.sv
// Shared types, widths and helper functions for the transposed matrix-vector multiply.
// Used by the interfaces and by every module of the block but tmvm_ram; depends on nothing.
package tmvm_pkg;

    localparam int MAX_DIM = 256;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int SIZE_W  = 9;
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = 40;
    localparam int IDX_W   = 8;

    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic             first_row;
        logic             last_row;
        logic             last_col;
    } item_tag_t;

    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] col;
        logic [SUM_W-1:0] sum;
    } fwd_entry_t;

    // Highest row and column index in use for a programmed size, with the size
    // clamped to the range one to the maximum dimension.
    function automatic logic [DIM_W-1:0] dim_last(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m;
        begin
            m = size - SIZE_W'(1);
            if (size == '0)
            begin
                m = '0;
            end
            else if (size > SIZE_W'(MAX_DIM))
            begin
                m = SIZE_W'(MAX_DIM - 1);
            end
            return m[DIM_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/tmvm_if.sv
// Channel interfaces of the block: operand stream, result stream and size register write.
// Depends on tmvm_pkg for the field widths.
interface tmvm_operand_if;
    logic                              valid;
    logic                              ready;
    logic signed [tmvm_pkg::DATA_W-1:0] matrix_value;
    logic signed [tmvm_pkg::DATA_W-1:0] vector_value;

    modport source (output valid, output matrix_value, output vector_value, input ready);
    modport sink   (input valid, input matrix_value, input vector_value, output ready);
endinterface

interface tmvm_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [tmvm_pkg::SUM_W-1:0] result_value;
    logic [tmvm_pkg::IDX_W-1:0]        result_index;
    logic                             final_flag;

    modport source (output valid, output result_value, output result_index,
                    output final_flag, input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input final_flag, output ready);
endinterface

interface tmvm_config_if;
    logic                        valid;
    logic                        ready;
    logic [tmvm_pkg::SIZE_W-1:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

>>> rtl/core/tmvm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// A read at the address being written returns the old contents. No dependencies.
module tmvm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tmvm_seq.sv
// Row and column sequencer: holds the size register and the position of the next element.
// Depends on tmvm_pkg and the configuration interface.
module tmvm_seq (
    input  logic                clk,
    input  logic                rst_n,
    tmvm_config_if.sink         size_cfg,
    input  logic                accept,
    output tmvm_pkg::item_tag_t tag
);

    logic [tmvm_pkg::DIM_W-1:0] dim_last_reg;
    logic [tmvm_pkg::DIM_W-1:0] dim_last_next;
    logic [tmvm_pkg::DIM_W-1:0] col_reg;
    logic [tmvm_pkg::DIM_W-1:0] col_next;
    logic [tmvm_pkg::DIM_W-1:0] row_reg;
    logic [tmvm_pkg::DIM_W-1:0] row_next;

    assign size_cfg.ready = 1'b1;

    always_comb
    begin
        dim_last_next = dim_last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (size_cfg.valid)
        begin
            dim_last_next = tmvm_pkg::dim_last(size_cfg.size_in_use);
            col_next      = '0;
            row_next      = '0;
        end
        else if (accept)
        begin
            if (col_reg == dim_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == dim_last_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_last_reg <= tmvm_pkg::DIM_W'(tmvm_pkg::MAX_DIM - 1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            dim_last_reg <= dim_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    assign tag.col       = col_reg;
    assign tag.first_row = (row_reg == '0);
    assign tag.last_row  = (row_reg == dim_last_reg);
    assign tag.last_col  = (col_reg == dim_last_reg);

endmodule

>>> rtl/core/tmvm_mac.sv
// Multiply-accumulate pipeline around the column sum RAM, with write-back forwarding
// and the result register. Depends on tmvm_pkg, tmvm_ram and the stream interfaces.
module tmvm_mac (
    input  logic                clk,
    input  logic                rst_n,
    tmvm_operand_if.sink        operands,
    tmvm_result_if.source       results,
    input  tmvm_pkg::item_tag_t tag,
    output logic                accept
);

    localparam int SUM_W  = tmvm_pkg::SUM_W;
    localparam int PROD_W = tmvm_pkg::PROD_W;

    logic                              advance;
    logic                              wr_en;
    logic [SUM_W-1:0]                  rd_data;
    logic [SUM_W-1:0]                  operand;
    logic [SUM_W-1:0]                  sum;
    logic [SUM_W-1:0]                  prod_ext;

    logic                              s1_valid_reg;
    tmvm_pkg::item_tag_t               s1_tag_reg;
    logic signed [tmvm_pkg::DATA_W-1:0] s1_mat_reg;
    logic signed [tmvm_pkg::DATA_W-1:0] s1_vec_reg;

    logic                              s2_valid_reg;
    tmvm_pkg::item_tag_t               s2_tag_reg;
    logic signed [PROD_W-1:0]          s2_prod_reg;
    logic [SUM_W-1:0]                  s2_mem_reg;

    tmvm_pkg::fwd_entry_t              fwd1_reg;
    tmvm_pkg::fwd_entry_t              fwd2_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [SUM_W-1:0]                  out_value_reg;
    logic [tmvm_pkg::IDX_W-1:0]        out_index_reg;
    logic                              out_final_reg;

    // The pipeline halts only when a result must enter a result register that is still held.
    assign advance = !(s2_valid_reg && s2_tag_reg.last_row && out_valid_reg && !results.ready);
    assign operands.ready = advance;
    assign accept = operands.valid && advance;
    assign wr_en = advance && s2_valid_reg;

    tmvm_ram #(
        .DEPTH (tmvm_pkg::MAX_DIM),
        .WIDTH (SUM_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_tag_reg.col),
        .wr_data (sum),
        .rd_en   (accept),
        .rd_addr (tag.col),
        .rd_data (rd_data)
    );

    // The RAM read misses the writes of the two items ahead, so those are forwarded.
    always_comb
    begin
        if (fwd1_reg.valid && fwd1_reg.col == s2_tag_reg.col)
        begin
            operand = fwd1_reg.sum;
        end
        else if (fwd2_reg.valid && fwd2_reg.col == s2_tag_reg.col)
        begin
            operand = fwd2_reg.sum;
        end
        else
        begin
            operand = s2_mem_reg;
        end
    end

    assign prod_ext = {{(SUM_W - PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
    assign sum = s2_tag_reg.first_row ? prod_ext : operand + prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd1_reg      <= '0;
            fwd2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg   <= accept;
                s2_valid_reg   <= s1_valid_reg;
                fwd1_reg.valid <= s2_valid_reg;
                fwd1_reg.col   <= s2_tag_reg.col;
                fwd1_reg.sum   <= sum;
                fwd2_reg       <= fwd1_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tag_reg <= tag;
            s1_mat_reg <= operands.matrix_value;
            s1_vec_reg <= operands.vector_value;
        end
        if (advance)
        begin
            s2_tag_reg    <= s1_tag_reg;
            s2_prod_reg   <= s1_mat_reg * s1_vec_reg;
            s2_mem_reg    <= rd_data;
        end
        if (advance && s2_valid_reg && s2_tag_reg.last_row)
        begin
            out_value_reg <= sum;
            out_index_reg <= tmvm_pkg::IDX_W'(s2_tag_reg.col);
            out_final_reg <= s2_tag_reg.last_col;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (advance && s2_valid_reg && s2_tag_reg.last_row)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_value = $signed(out_value_reg);
    assign results.result_index = out_index_reg;
    assign results.final_flag   = out_final_reg;

endmodule

>>> rtl/core/transposed_matrix_vector_multiply.sv
// Top level of the transposed matrix-vector multiply block.
// Depends on tmvm_pkg, the channel interfaces, tmvm_seq and tmvm_mac.
//
// The block takes one matrix element per cycle in row-major order, each transaction
// carrying the vector element of its row, and keeps one 40-bit sum per column in a
// 256-entry RAM. Every transaction reads its column's sum as it is accepted, is multiplied
// from pipeline stage s1 and is added and written back from stage s2, so a sustained rate
// of one transaction per cycle holds while the operand channel does not stall; sums still
// in flight are forwarded to the adder. During the last row each transaction presents its
// column's finished sum on the result channel through the result register after stage s2,
// with the last column flagged final. The operand channel stalls only while a result is
// held in the output register and the next result is ready behind it.
// The sums need no clearing after reset, since the first row loads them. Writing the
// size register restarts the run at row zero and must be done while the block is idle.
module transposed_matrix_vector_multiply (
    input  logic          clk,
    input  logic          rst_n,
    tmvm_operand_if.sink  operands,
    tmvm_result_if.source results,
    tmvm_config_if.sink   size_cfg
);

    tmvm_pkg::item_tag_t tag;
    logic                accept;

    tmvm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .size_cfg (size_cfg),
        .accept   (accept),
        .tag      (tag)
    );

    tmvm_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .results  (results),
        .tag      (tag),
        .accept   (accept)
    );

    // The operand channel may only stall behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !operands.ready |-> (results.valid && !results.ready))
        else $error("operand channel stalled without a held result");

    // The element after the last one of a run starts a new run at the first column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tag.last_row && tag.last_col) |=> (tag.col == '0 && tag.first_row))
        else $error("run did not wrap to the first row and column");

endmodule

>>> test/tb_transposed_matrix_vector_multiply.sv
// Self-checking testbench for the transposed matrix-vector multiply block.
// Depends on tmvm_pkg, the channel interfaces in tmvm_if.sv and the block's top level.
`timescale 1ns / 100ps

module tb_transposed_matrix_vector_multiply;

    localparam int MAX_DIM = tmvm_pkg::MAX_DIM;
    localparam int DIM_W   = tmvm_pkg::DIM_W;
    localparam int SIZE_W  = tmvm_pkg::SIZE_W;
    localparam int DATA_W  = tmvm_pkg::DATA_W;
    localparam int PROD_W  = tmvm_pkg::PROD_W;
    localparam int SUM_W   = tmvm_pkg::SUM_W;
    localparam int IDX_W   = tmvm_pkg::IDX_W;

    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = DATA_W'(-32768);
    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = DATA_W'(32767);
    localparam int unsigned              RANDOM_ITEMS = 1300;

    typedef struct {
        logic signed [SUM_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    last_col;
    } column_result_t;

    class column_sum_board;
        logic [SIZE_W-1:0] size_reg;
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [SUM_W-1:0]  column_sums [MAX_DIM];
        column_result_t    finished_columns [$];
        int unsigned       operand_count;
        int unsigned       result_count;
        int unsigned       size_writes;
        int unsigned       errors;

        function new();
            size_reg = SIZE_W'(MAX_DIM);
            col_pos = 0;
            row_pos = 0;
            operand_count = 0;
            result_count = 0;
            size_writes = 0;
            errors = 0;
        endfunction

        function int unsigned active_dim();
            int unsigned n;
            n = 32'(size_reg);
            if (n < 1)
            begin
                n = 1;
            end
            if (n > MAX_DIM)
            begin
                n = MAX_DIM;
            end
            return n;
        endfunction

        function void set_size(logic [SIZE_W-1:0] size);
            size_reg = size;
            col_pos = 0;
            row_pos = 0;
            size_writes++;
        endfunction

        function void accumulate_element(logic signed [DATA_W-1:0] mat,
                                         logic signed [DATA_W-1:0] vec);
            int unsigned              n;
            logic signed [PROD_W-1:0] product;
            logic [SUM_W-1:0]         product_ext;
            logic [SUM_W-1:0]         sum;
            column_result_t           done;
            n = active_dim();
            product = mat * vec;
            product_ext = {{(SUM_W-PROD_W){product[PROD_W-1]}}, product};
            if (row_pos == 0)
            begin
                sum = product_ext;
            end
            else
            begin
                sum = column_sums[DIM_W'(col_pos)] + product_ext;
            end
            column_sums[DIM_W'(col_pos)] = sum;
            if (row_pos == n - 1)
            begin
                done.value = sum;
                done.index = IDX_W'(col_pos);
                done.last_col = (col_pos == n - 1);
                finished_columns.push_back(done);
            end
            operand_count++;
            col_pos++;
            if (col_pos >= n)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= n)
                begin
                    row_pos = 0;
                end
            end
        endfunction

        function void check_result(logic signed [SUM_W-1:0] value, logic [IDX_W-1:0] index,
                                   logic last_col);
            column_result_t want;
            if (finished_columns.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transaction: value %0d index %0d final %0b",
                         $time, value, index, last_col);
                return;
            end
            want = finished_columns.pop_front();
            result_count++;
            if (value !== want.value || index !== want.index || last_col !== want.last_col)
            begin
                errors++;
                $display("%0t: result mismatch: expected value %0d index %0d final %0b,",
                         $time, want.value, want.index, want.last_col,
                         " got value %0d index %0d final %0b", value, index, last_col);
            end
        endfunction

        function int unsigned pending();
            return finished_columns.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tmvm_operand_if operands();
    tmvm_result_if  results();
    tmvm_config_if  size_cfg();

    transposed_matrix_vector_multiply dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .results  (results),
        .size_cfg (size_cfg)
    );

    column_sum_board board = new();
    int unsigned     operand_gap_max = 15;
    int unsigned     result_gap_max = 15;
    int unsigned     result_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return '0;
            3: return DATA_W'(-1);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_operand(input logic signed [DATA_W-1:0] mat,
                                input logic signed [DATA_W-1:0] vec);
        int unsigned gap;
        gap = $urandom_range(0, operand_gap_max);
        if (gap > 0)
        begin
            operands.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operands.valid <= 1'b1;
        operands.matrix_value <= mat;
        operands.vector_value <= vec;
        do @(posedge clk); while (!operands.ready);
        board.accumulate_element(mat, vec);
        @(negedge clk);
    endtask

    task automatic drain();
        operands.valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        size_cfg.valid <= 1'b1;
        size_cfg.size_in_use <= size;
        do @(posedge clk); while (!size_cfg.ready);
        board.set_size(size);
        @(negedge clk);
        size_cfg.valid <= 1'b0;
    endtask

    task automatic run_matrix_rows(input bit fixed_vector, input int rows);
        logic signed [DATA_W-1:0] vec;
        logic signed [DATA_W-1:0] mat;
        for (int row = 0; row < rows; row++)
        begin
            vec = fixed_vector ? SAMPLE_MIN : random_sample();
            if (row == rows - 1 || $urandom_range(0, 255) == 0)
            begin
                operand_gap_max = 15;
            end
            else
            begin
                operand_gap_max = 0;
            end
            for (int col = 0; col < MAX_DIM; col++)
            begin
                if (col == 0)
                begin
                    mat = SAMPLE_MIN;
                end
                else if (col == 1)
                begin
                    mat = SAMPLE_MAX;
                end
                else
                begin
                    mat = random_sample();
                end
                send_operand(mat, vec);
            end
        end
        operand_gap_max = 15;
    endtask

    initial
    begin
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (result_hold > 0)
            begin
                results.ready <= 1'b0;
                result_hold--;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            board.check_result(results.result_value, results.result_index, results.final_flag);
            result_hold = $urandom_range(0, result_gap_max);
        end
    end

    initial
    begin
        int unsigned              n;
        int unsigned              count;
        int unsigned              random_items;
        int unsigned              phase_no;
        int unsigned              pick;
        logic [SIZE_W-1:0]        size_sel;
        logic signed [DATA_W-1:0] row_vec;

        rst_n = 1'b0;
        operands.valid = 1'b0;
        operands.matrix_value = '0;
        operands.vector_value = '0;
        size_cfg.valid = 1'b0;
        size_cfg.size_in_use = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_matrix_rows(1'b1, 1);
        drain();

        write_size(SIZE_W'(1));
        send_operand(SAMPLE_MAX, SAMPLE_MAX);
        send_operand(SAMPLE_MIN, SAMPLE_MIN);
        send_operand(SAMPLE_MIN, SAMPLE_MAX);
        send_operand('0, SAMPLE_MIN);
        send_operand(DATA_W'(-1), DATA_W'(-1));
        drain();
        write_size(SIZE_W'(0));
        send_operand(SAMPLE_MAX, SAMPLE_MIN);
        send_operand(DATA_W'(1), DATA_W'(1));
        send_operand(SAMPLE_MIN, DATA_W'(-1));
        drain();
        write_size(SIZE_W'(2));
        send_operand(SAMPLE_MAX, SAMPLE_MIN);
        send_operand(SAMPLE_MIN, SAMPLE_MIN);
        send_operand(SAMPLE_MIN, SAMPLE_MAX);
        send_operand(SAMPLE_MAX, SAMPLE_MAX);
        drain();
        write_size(SIZE_W'(3));
        for (int k = 0; k < 5; k++)
        begin
            send_operand(random_sample(), SAMPLE_MAX);
        end
        drain();
        write_size(SIZE_W'(3));
        for (int k = 0; k < 9; k++)
        begin
            send_operand(random_sample(), SAMPLE_MIN);
        end
        drain();

        write_size(SIZE_W'(511));
        run_matrix_rows(1'b0, 1);
        drain();

        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                size_sel = SIZE_W'($urandom_range(0, 1));
            end
            else if (pick < 8)
            begin
                size_sel = SIZE_W'($urandom_range(2, 8));
            end
            else
            begin
                size_sel = SIZE_W'($urandom_range(9, 24));
            end
            write_size(size_sel);
            n = board.active_dim();
            if ($urandom_range(0, 3) == 0)
            begin
                count = $urandom_range(1, 2 * n * n);
            end
            else
            begin
                count = n * n * $urandom_range(1, 3);
            end
            if (count > RANDOM_ITEMS - random_items)
            begin
                count = RANDOM_ITEMS - random_items;
            end
            operand_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
            result_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
            row_vec = random_sample();
            for (int k = 0; k < count; k++)
            begin
                if (k % n == 0)
                begin
                    row_vec = random_sample();
                end
                if ((phase_no == 0 || $urandom_range(0, 3) == 0) && k == count / 2 && k > 0)
                begin
                    drain();
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    send_operand(random_sample(), random_sample());
                end
                else
                begin
                    send_operand(random_sample(), row_vec);
                end
            end
            random_items += count;
            phase_no++;
            drain();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d operand and %0d result transactions across %0d size writes,",
                 board.operand_count, board.result_count, board.size_writes);
        $display("with sizes zero, one, the default and above the maximum, stalls and drains.");
        if (board.errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tmvm_pkg.sv
rtl/core/tmvm_if.sv
rtl/core/tmvm_ram.sv
rtl/core/tmvm_seq.sv
rtl/core/tmvm_mac.sv
rtl/core/transposed_matrix_vector_multiply.sv
test/tb_transposed_matrix_vector_multiply.sv
